// ----- rtl/fgc_pkg.sv -----
// shared types and constants of the foreground centroid block
package fgc_pkg;

  localparam int CHAN_W  = 8;
  localparam int SIZE_W  = 13;
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 25;
  localparam int CFG_W   = 25;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [CNT_W-1:0]  MIN_COUNT_RST    = 25'd20;
  localparam logic [CHAN_W-1:0] BACKGROUND_RST   = 8'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_MIN_COUNT    = 2'd2,
    CFG_BACKGROUND   = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic             frame_end;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
  } acc_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/fgc_if.sv -----
// pixel and result channel interfaces
interface fgc_pix_if;
  import fgc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] chan_a;
  logic [CHAN_W-1:0] chan_b;
  logic [CHAN_W-1:0] chan_c;
  modport source (output valid, chan_a, chan_b, chan_c, input ready);
  modport sink (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface fgc_res_if #(parameter int COORD_BITS = 12);
  import fgc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [CNT_W-1:0]      pixel_count;
  modport source (output valid, found, center_x, center_y, pixel_count, input ready);
  modport sink (input valid, found, center_x, center_y, pixel_count, output ready);
endinterface

// ----- rtl/fgc_accum.sv -----
// raster position counters and foreground sums
module fgc_accum #(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic [fgc_pkg::CHAN_W-1:0] chan_a,
  input  logic [fgc_pkg::CHAN_W-1:0] chan_b,
  input  logic [fgc_pkg::CHAN_W-1:0] chan_c,
  input  logic [fgc_pkg::SIZE_W-1:0] frame_width,
  input  logic [fgc_pkg::SIZE_W-1:0] frame_height,
  input  logic [fgc_pkg::CHAN_W-1:0] background_level,
  output fgc_pkg::acc_t             acc
);
  import fgc_pkg::*;

  localparam int SZ_W = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
  localparam logic [SZ_W-1:0] SIZE_LIM = SZ_W'(1) << COORD_BITS;

  logic [COORD_BITS-1:0] col_pos;
  logic [COORD_BITS-1:0] row_pos;
  logic [SUM_W-1:0]      sum_x;
  logic [SUM_W-1:0]      sum_y;
  logic [CNT_W-1:0]      fg_count;

  logic [SZ_W-1:0] eff_w;
  logic [SZ_W-1:0] eff_h;
  logic            fg;
  logic            row_end;
  logic            row_last;

  // zero acts as one, oversize clamps to the coordinate range
  always_comb begin
    if (frame_width == '0) begin
      eff_w = SZ_W'(1);
    end else if (SZ_W'(frame_width) > SIZE_LIM) begin
      eff_w = SIZE_LIM;
    end else begin
      eff_w = SZ_W'(frame_width);
    end
    if (frame_height == '0) begin
      eff_h = SZ_W'(1);
    end else if (SZ_W'(frame_height) > SIZE_LIM) begin
      eff_h = SIZE_LIM;
    end else begin
      eff_h = SZ_W'(frame_height);
    end
  end

  assign fg = (chan_a != background_level) || (chan_b != background_level) ||
              (chan_c != background_level);
  assign row_end  = (SZ_W'(col_pos) + SZ_W'(1)) >= eff_w;
  assign row_last = (SZ_W'(row_pos) + SZ_W'(1)) >= eff_h;

  assign acc.frame_end = row_end && row_last;
  assign acc.sum_x = sum_x + (fg ? SUM_W'(col_pos) : '0);
  assign acc.sum_y = sum_y + (fg ? SUM_W'(row_pos) : '0);
  assign acc.count = fg_count + CNT_W'(fg);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      sum_x    <= '0;
      sum_y    <= '0;
      fg_count <= '0;
    end else if (take) begin
      if (row_end) begin
        col_pos <= '0;
        row_pos <= row_last ? '0 : row_pos + COORD_BITS'(1);
      end else begin
        col_pos <= col_pos + COORD_BITS'(1);
      end
      if (acc.frame_end) begin
        sum_x    <= '0;
        sum_y    <= '0;
        fg_count <= '0;
      end else begin
        sum_x    <= acc.sum_x;
        sum_y    <= acc.sum_y;
        fg_count <= acc.count;
      end
    end
  end

endmodule

// ----- rtl/fgc_divider.sv -----
// shared restoring divider, one quotient bit per cycle
module fgc_divider #(
  parameter int COORD_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fgc_pkg::SUM_W-1:0]  dividend,
  input  logic [fgc_pkg::CNT_W-1:0]  divisor,
  output fgc_pkg::div_stat_t         stat,
  output logic [COORD_BITS-1:0]      quotient
);
  import fgc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  dvd;
  logic [CNT_W-1:0]  dsr;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [CNT_W:0] rem_sh;
  logic [CNT_W:0] diff;
  logic           ge;

  assign rem_sh = {rem, dvd[SUM_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      dvd <= {dvd[SUM_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd[COORD_BITS-1:0];

endmodule

// ----- rtl/foreground_centroid_core.sv -----
// top level of the foreground centroid block
//
// pixels arrive on pix in raster order, one request per pixel; a pixel is
// foreground when any of its three channels differs from background_level.
// the column and row counters follow frame_width and frame_height; the last
// pixel of a frame yields one request on res with the foreground count and,
// when that count exceeds min_count, the truncated mean column and row.
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, the block does not enforce it. within a frame
// pix takes one pixel every cycle. after the last pixel of a frame pix drops
// ready while the shared divider finds the mean column, then the mean row,
// and while the output register loads; no division runs without a centroid.
// the result then sits in the output register and pix is ready again.
// if res stalls, a finished result waits for the output register to free
// before pix reopens. reset clears counters, sums and the output valid and
// loads the register defaults.
module foreground_centroid_core #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fgc_pkg::CFG_W-1:0]     cfg_data,
  fgc_pix_if.sink                       pix,
  fgc_res_if.source                     res
);
  import fgc_pkg::*;

  typedef enum logic [3:0] {
    S_ACC  = 4'b0001,
    S_DIVX = 4'b0010,
    S_DIVY = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic [CNT_W-1:0]  min_count;
  logic [CHAN_W-1:0] background_level;

  acc_t                  acc;
  div_stat_t             div_stat;
  logic                  take;
  logic                  div_start;
  logic [SUM_W-1:0]      div_dividend;
  logic [CNT_W-1:0]      div_divisor;
  logic [COORD_BITS-1:0] div_quotient;
  logic                  found_now;
  logic                  load_out;

  logic [SUM_W-1:0]      sum_y_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  found_r;
  logic [COORD_BITS-1:0] cx_r;
  logic [COORD_BITS-1:0] cy_r;

  logic                  out_valid;
  logic                  out_found;
  logic [COORD_BITS-1:0] out_cx;
  logic [COORD_BITS-1:0] out_cy;
  logic [CNT_W-1:0]      out_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= FRAME_WIDTH_RST;
      frame_height     <= FRAME_HEIGHT_RST;
      min_count        <= MIN_COUNT_RST;
      background_level <= BACKGROUND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width      <= cfg_data[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: frame_height     <= cfg_data[SIZE_W-1:0];
        CFG_MIN_COUNT:    min_count        <= cfg_data[CNT_W-1:0];
        CFG_BACKGROUND:   background_level <= cfg_data[CHAN_W-1:0];
      endcase
    end
  end

  assign pix.ready = (state == S_ACC);
  assign take      = pix.valid && pix.ready;

  fgc_accum #(.COORD_BITS(COORD_BITS)) u_accum (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .chan_a           (pix.chan_a),
    .chan_b           (pix.chan_b),
    .chan_c           (pix.chan_c),
    .frame_width      (frame_width),
    .frame_height     (frame_height),
    .background_level (background_level),
    .acc              (acc)
  );

  assign found_now    = acc.count > min_count;
  assign div_dividend = (state == S_ACC) ? acc.sum_x : sum_y_r;
  assign div_divisor  = (state == S_ACC) ? acc.count : cnt_r;
  assign load_out     = (state == S_PUSH) && (!out_valid || res.ready);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      S_ACC: begin
        if (take && acc.frame_end) begin
          if (found_now) begin
            div_start  = 1'b1;
            state_next = S_DIVX;
          end else begin
            state_next = S_PUSH;
          end
        end
      end
      S_DIVX: begin
        if (div_stat.done) begin
          div_start  = 1'b1;
          state_next = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_stat.done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (load_out) begin
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  fgc_divider #(.COORD_BITS(COORD_BITS)) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ACC && take && acc.frame_end) begin
      sum_y_r <= acc.sum_y;
      cnt_r   <= acc.count;
      found_r <= found_now;
      cx_r    <= '0;
      cy_r    <= '0;
    end else if (state == S_DIVX && div_stat.done) begin
      cx_r <= div_quotient;
    end else if (state == S_DIVY && div_stat.done) begin
      cy_r <= div_quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found <= found_r;
      out_cx    <= cx_r;
      out_cy    <= cy_r;
      out_count <= cnt_r;
    end
  end

  assign res.valid       = out_valid;
  assign res.found       = out_found;
  assign res.center_x    = out_cx;
  assign res.center_y    = out_cy;
  assign res.pixel_count = out_count;

endmodule

// ----- rtl/fgc_checker.sv -----
// port level checks for the foreground centroid block
module fgc_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         pix_valid,
  input logic                         pix_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         found,
  input logic [COORD_BITS-1:0]        center_x,
  input logic [COORD_BITS-1:0]        center_y,
  input logic [fgc_pkg::CNT_W-1:0]    pixel_count
);
  import fgc_pkg::*;

  // no centroid means zero coordinates
  a_zero_when_missing: assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> center_x == '0 && center_y == '0)
    else $error("coordinates set without a centroid");

  // a centroid needs at least one foreground pixel
  a_found_has_pixels: assert property (@(posedge clk) disable iff (rst)
    res_valid && found |-> pixel_count != '0)
    else $error("centroid reported with zero pixels");

  // input closes only right after a pixel request
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(pix_ready) |-> $past(pix_valid && pix_ready))
    else $error("pixel ready dropped without a request");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(found) && $stable(center_x) &&
      $stable(center_y) && $stable(pixel_count))
    else $error("stalled result changed");

endmodule

bind foreground_centroid_core fgc_checker #(.COORD_BITS(COORD_BITS)) u_fgc_checker (
  .clk         (clk),
  .rst         (rst),
  .pix_valid   (pix.valid),
  .pix_ready   (pix.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .found       (res.found),
  .center_x    (res.center_x),
  .center_y    (res.center_y),
  .pixel_count (res.pixel_count)
);
